// ----- rtl/core/tev_pkg.sv -----
// types, constants and helper functions shared by the trace event encoder
package tev_pkg;

	localparam int unsigned CMD_W   = 4;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned GROUP_W = 7;
	localparam int unsigned CODE_W  = 5;
	localparam int unsigned CFG_W   = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_END_STREAM  = 4'd0,
		CMD_DESTROY     = 4'd1,
		CMD_ADD_CORE    = 4'd2,
		CMD_GROW        = 4'd3,
		CMD_REMOVE      = 4'd4,
		CMD_SHRINK      = 4'd5,
		CMD_ALLOCATE    = 4'd6,
		CMD_FREE        = 4'd7,
		CMD_FREE_ALL    = 4'd8,
		CMD_SET_BACKING = 4'd9
	} cmd_t;

	typedef enum logic [CFG_W-1:0] {
		REG_ENABLE    = 1'b0,
		REG_TIME_BASE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY
	} state_t;

	typedef enum logic [3:0] {
		F_COUNT,
		F_CODE,
		F_TIME,
		F_TID,
		F_HEAP,
		F_ADDR,
		F_LEN,
		F_BOOL,
		F_HEAP2,
		F_CODE2
	} field_t;

	localparam logic [CODE_W-1:0] CODE_END_STREAM  = 5'd2;
	localparam logic [CODE_W-1:0] CODE_DESTROY     = 5'd11;
	localparam logic [CODE_W-1:0] CODE_ADD_CORE    = 5'd12;
	localparam logic [CODE_W-1:0] CODE_GROW        = 5'd13;
	localparam logic [CODE_W-1:0] CODE_REMOVE      = 5'd14;
	localparam logic [CODE_W-1:0] CODE_SHRINK      = 5'd15;
	localparam logic [CODE_W-1:0] CODE_ALLOCATE    = 5'd16;
	localparam logic [CODE_W-1:0] CODE_FREE        = 5'd17;
	localparam logic [CODE_W-1:0] CODE_FREE_ALL    = 5'd18;
	localparam logic [CODE_W-1:0] CODE_SET_BACKING = 5'd30;

	function automatic logic cmd_known(input logic [CMD_W-1:0] c);
		return c <= CMD_SET_BACKING;
	endfunction

	function automatic logic [CODE_W-1:0] cmd_code(input cmd_t c);
		logic [CODE_W-1:0] r;
		unique case (c)
			CMD_END_STREAM:  r = CODE_END_STREAM;
			CMD_DESTROY:     r = CODE_DESTROY;
			CMD_ADD_CORE:    r = CODE_ADD_CORE;
			CMD_GROW:        r = CODE_GROW;
			CMD_REMOVE:      r = CODE_REMOVE;
			CMD_SHRINK:      r = CODE_SHRINK;
			CMD_ALLOCATE:    r = CODE_ALLOCATE;
			CMD_FREE:        r = CODE_FREE;
			CMD_FREE_ALL:    r = CODE_FREE_ALL;
			CMD_SET_BACKING: r = CODE_SET_BACKING;
			default:         r = CODE_END_STREAM;
		endcase
		return r;
	endfunction

	// record layout: which field follows the current one for a command
	function automatic field_t next_field(input cmd_t c, input field_t f);
		field_t r;
		unique case (f)
			F_COUNT: r = F_CODE;
			F_CODE:  r = F_TIME;
			F_TIME:  r = F_TID;
			F_TID:   r = (c == CMD_END_STREAM) ? F_CODE2 : F_HEAP;
			F_HEAP: begin
				case (c) inside
					CMD_ADD_CORE, CMD_GROW, CMD_REMOVE, CMD_SHRINK, CMD_ALLOCATE,
					CMD_FREE:        r = F_ADDR;
					CMD_SET_BACKING: r = F_HEAP2;
					default:         r = F_CODE2;
				endcase
			end
			F_ADDR:  r = (c == CMD_FREE) ? F_BOOL : F_LEN;
			F_LEN:   r = (c == CMD_ALLOCATE) ? F_BOOL : F_CODE2;
			F_BOOL:  r = F_CODE2;
			F_HEAP2: r = F_CODE2;
			F_CODE2: r = F_CODE2;
			default: r = F_CODE2;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/tev_if.sv -----
// handshake channels of the trace event encoder: events, stream words, register writes
interface tev_evt_if;
	logic                                valid;
	logic                                ready;
	logic [tev_pkg::CMD_W-1:0]           command;
	logic [tev_pkg::ID_W-1:0]            heap_id;
	logic [tev_pkg::ID_W-1:0]            second_heap_id;
	logic [tev_pkg::WORD_W-1:0]          address;
	logic [tev_pkg::WORD_W-1:0]          length;
	logic                                by_heap;
	logic [tev_pkg::WORD_W-1:0]          timestamp;
	logic [tev_pkg::ID_W-1:0]            thread_id;

	modport source (
		output valid, command, heap_id, second_heap_id, address, length, by_heap,
			timestamp, thread_id,
		input  ready
	);
	modport sink (
		input  valid, command, heap_id, second_heap_id, address, length, by_heap,
			timestamp, thread_id,
		output ready
	);
endinterface

interface tev_byte_if;
	logic                        valid;
	logic                        ready;
	logic [tev_pkg::BYTE_W-1:0]  out_byte;
	logic                        last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

interface tev_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tev_pkg::CFG_W-1:0]    index;
	logic [tev_pkg::WORD_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/trace_event_varint_encoder.sv -----
// heap trace event to varint byte stream encoder, top level
//
// evt carries one heap trace event per word; bytes carries the encoded
// record, one byte per word, with last set on the record's final byte.
// cfg writes register 0 (enable, bit 0) and register 1 (time base, 64 bit);
// cfg is always ready; it must be written only while no record is in flight,
// which the block itself does not enforce. an accepted event with enable low
// or an unknown command makes no bytes and the block stays ready.
// otherwise a record of n bytes (5 to 53) is produced by one 64 bit shift
// register that drops 7 bits a cycle under a small field sequencer, so one
// byte leaves per cycle while the receiver is not stalling; evt is not ready
// until the record's last byte has been passed to the output register.
// each byte is registered in the output register on its way out of the shift register.
// a stalled receiver holds the output register, and the sequencer waits
// with it; no byte is lost or repeated.
// reset clears enable, time base and the event count and empties the
// output register.
module trace_event_varint_encoder (
	input  logic        clk,
	input  logic        arst_n,
	tev_evt_if.sink     evt,
	tev_byte_if.source  bytes,
	tev_cfg_if.sink     cfg
);

	tev_pkg::state_t                  state_q, state_d;
	tev_pkg::field_t                  field_q, field_d, nf;
	tev_pkg::cmd_t                    cmd_q;
	logic [tev_pkg::WORD_W-1:0]       sh_q, sh_d, rest, nval;
	logic [tev_pkg::WORD_W-1:0]       count_q, time_base_q, tsd_q, addr_q, len_q;
	logic [tev_pkg::ID_W-1:0]         heap_q, heap2_q, tid_q;
	logic                             byh_q, enable_q;
	logic                             ov_q;
	logic [tev_pkg::BYTE_W-1:0]       ob_q, ob_d;
	logic                             ol_q, ol_d;
	logic                             evt_acc, start, push, fin;

	assign evt.ready     = (state_q == tev_pkg::ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign bytes.valid   = ov_q;
	assign bytes.out_byte = ob_q;
	assign bytes.last    = ol_q;

	assign evt_acc = evt.valid && evt.ready;
	assign start   = evt_acc && enable_q && tev_pkg::cmd_known(evt.command);
	assign push    = (state_q == tev_pkg::ST_BUSY) && (!ov_q || bytes.ready);
	assign rest    = sh_q >> tev_pkg::GROUP_W;
	assign fin     = (rest == '0);
	assign nf      = tev_pkg::next_field(cmd_q, field_q);

	always_comb begin
		unique case (nf)
			tev_pkg::F_COUNT: nval = count_q;
			tev_pkg::F_CODE,
			tev_pkg::F_CODE2: nval = {{(tev_pkg::WORD_W-tev_pkg::CODE_W){1'b0}},
				tev_pkg::cmd_code(cmd_q)};
			tev_pkg::F_TIME:  nval = tsd_q;
			tev_pkg::F_TID:   nval = {{(tev_pkg::WORD_W-tev_pkg::ID_W){1'b0}}, tid_q};
			tev_pkg::F_HEAP:  nval = {{(tev_pkg::WORD_W-tev_pkg::ID_W){1'b0}}, heap_q};
			tev_pkg::F_ADDR:  nval = addr_q;
			tev_pkg::F_LEN:   nval = len_q;
			tev_pkg::F_BOOL:  nval = {{(tev_pkg::WORD_W-1){1'b0}}, byh_q};
			tev_pkg::F_HEAP2: nval = {{(tev_pkg::WORD_W-tev_pkg::ID_W){1'b0}}, heap2_q};
			default:          nval = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		field_d = field_q;
		sh_d    = sh_q;
		ob_d    = {fin, sh_q[tev_pkg::GROUP_W-1:0]};
		ol_d    = fin && (field_q == tev_pkg::F_CODE2);
		unique case (state_q)
			tev_pkg::ST_IDLE: begin
				if (start) begin
					state_d = tev_pkg::ST_BUSY;
					field_d = tev_pkg::F_COUNT;
					sh_d    = count_q;
				end
			end
			tev_pkg::ST_BUSY: begin
				if (push) begin
					if (!fin) begin
						sh_d = rest;
					end else if (field_q == tev_pkg::F_CODE2) begin
						state_d = tev_pkg::ST_IDLE;
					end else begin
						field_d = nf;
						sh_d    = nval;
					end
				end
			end
			default: state_d = tev_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tev_pkg::ST_IDLE;
			count_q     <= '0;
			enable_q    <= 1'b0;
			time_base_q <= '0;
			ov_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push && ol_d) begin
				count_q <= count_q + 64'd1;
			end
			if (cfg.valid && cfg.ready) begin
				unique case (tev_pkg::cfg_reg_t'(cfg.index))
					tev_pkg::REG_ENABLE:    enable_q    <= cfg.data[0];
					tev_pkg::REG_TIME_BASE: time_base_q <= cfg.data;
					default: ;
				endcase
			end
			if (push) begin
				ov_q <= 1'b1;
			end else if (bytes.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		field_q <= field_d;
		sh_q    <= sh_d;
		if (push) begin
			ob_q <= ob_d;
			ol_q <= ol_d;
		end
		if (evt_acc) begin
			cmd_q   <= tev_pkg::cmd_t'(evt.command);
			heap_q  <= evt.heap_id;
			heap2_q <= evt.second_heap_id;
			addr_q  <= evt.address;
			len_q   <= evt.length;
			byh_q   <= evt.by_heap;
			tid_q   <= evt.thread_id;
			tsd_q   <= evt.timestamp - time_base_q;
		end
	end

	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		bytes.valid && bytes.last |-> bytes.out_byte[tev_pkg::BYTE_W-1])
		else $error("record end byte without stop bit");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && ol_d |=> count_q == $past(count_q) + 64'd1)
		else $error("event count not advanced at record end");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && ol_d) |=> count_q == $past(count_q))
		else $error("event count moved outside record end");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		evt_acc && !enable_q |=> state_q == tev_pkg::ST_IDLE)
		else $error("record started while disabled");

endmodule
